// ----- hw/rtl/ilt_pkg.sv -----
// ilt_pkg: shared sizes, operation codes and the command/status structs
// of the index liveness table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ilt_pkg;

    localparam int MAX_DIMS   = 64;
    localparam int COUNT_BITS = 8;
    localparam int ID_W       = 6;
    localparam int OP_W       = 2;
    localparam int DIMS_W     = 7;
    localparam int TDATA_W    = 8;
    localparam int ADDR_W     = $clog2(MAX_DIMS);
    localparam int LIM_CAP    = (MAX_DIMS < 64) ? MAX_DIMS : 64;

    localparam logic [DIMS_W-1:0]     DIMS_RESET = DIMS_W'(64);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OP_W-1:0] OP_COUNT    = 2'd1;
    localparam logic [OP_W-1:0] OP_CONTRACT = 2'd2;

    typedef struct packed {
        logic accept;
        logic item_rd;
        logic item_wr;
        logic scan_init;
        logic scan_rd;
        logic scan_chk;
        logic finish;
    } ilt_cmd_t;

    typedef struct packed {
        logic op_update;
        logic op_contract;
        logic last_of_pair;
        logic lim_zero;
        logic scan_stall;
        logic scan_at_end;
        logic out_free;
    } ilt_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/index_liveness_table.sv -----
// index_liveness_table: top level, joins the sequencer and the datapath.
// Depends on ilt_pkg, ilt_ctrl, ilt_dp (and ilt_ram through ilt_dp).
`timescale 1ns / 1ps
`default_nettype none

// Keeps a saturating occurrence count per index id and, on the last contract
// request of a pair, streams out every marked id whose count is still above
// zero, in ascending order, bumping each such count; with none, one result
// flagged empty (m_tuser high, id zero, m_tlast high) goes out instead.
// Requests are taken one at a time: a clear has only a read step, a count or
// contract a read step then a write step, since every update is a read,
// modify and write of the count ram, whose read data comes back registered.
// A contract request with s_tlast set then sweeps each id in use (a ram
// read then a check) and ends with a step for the closing result; both can
// wait while the result side stalls. A clear costs no sweep:
// per-entry valid bits mark cleared counts as zero. A waiting result does
// not block a new request; only the next emission waits for it.
module index_liveness_table (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration: dims_in_use
    input  wire logic                        cfg_wr_en,
    input  wire logic [ilt_pkg::DIMS_W-1:0]  cfg_wr_data,
    // request side
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [ilt_pkg::TDATA_W-1:0] s_tdata,   // [5:0] dim_id, rest zero
    input  wire logic [ilt_pkg::OP_W-1:0]    s_tuser,   // [1:0] operation
    input  wire logic                        s_tlast,   // last_of_pair
    // result side
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [ilt_pkg::TDATA_W-1:0] m_tdata,   // [5:0] out_dim_id, rest zero
    output logic                             m_tuser,   // is_empty
    output logic                             m_tlast    // last
);

    // command and status between sequencer and datapath
    ilt_pkg::ilt_cmd_t  cmd;
    ilt_pkg::ilt_stat_t stat;

    // sequencer: request decode, read/modify/write and scan steps
    ilt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: counts, marks, scan counter and result register
    ilt_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ilt_ram.sv -----
// ilt_ram: generic single-write, single-read ram with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ilt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ilt_ctrl.sv -----
// ilt_ctrl: sequencer of the index liveness table, item read/modify/write
// and the emission scan. Depends on ilt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire ilt_pkg::ilt_stat_t stat,
    output ilt_pkg::ilt_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ITEM_RD  = 3'd1;
    localparam logic [2:0] S_ITEM_WR  = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CHK = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_ITEM_RD;
                end
            end
            S_ITEM_RD: begin
                cmd.item_rd = 1'b1;
                state_next  = stat.op_update ? S_ITEM_WR : S_IDLE;
            end
            S_ITEM_WR: begin
                cmd.item_wr = 1'b1;
                if (stat.op_contract && stat.last_of_pair) begin
                    cmd.scan_init = 1'b1;
                    state_next    = stat.lim_zero ? S_FINISH : S_SCAN_RD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                cmd.scan_chk = 1'b1;
                if (!stat.scan_stall) begin
                    state_next = stat.scan_at_end ? S_FINISH : S_SCAN_RD;
                end
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ilt_dp.sv -----
// ilt_dp: datapath of the index liveness table: count ram, valid and mark
// flags, scan counter, pending result and output register.
// Depends on ilt_pkg and ilt_ram.
`timescale 1ns / 1ps
`default_nettype none

module ilt_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ilt_pkg::DIMS_W-1:0]    cfg_wr_data,
    input  wire logic [ilt_pkg::TDATA_W-1:0]   s_tdata,
    input  wire logic [ilt_pkg::OP_W-1:0]      s_tuser,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [ilt_pkg::TDATA_W-1:0]   m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  wire ilt_pkg::ilt_cmd_t             cmd,
    output ilt_pkg::ilt_stat_t                 stat
);

    localparam int AW = ilt_pkg::ADDR_W;
    localparam int CW = ilt_pkg::COUNT_BITS;
    localparam int DW = ilt_pkg::DIMS_W;
    localparam int IW = ilt_pkg::ID_W;
    localparam int ND = ilt_pkg::MAX_DIMS;

    logic [DW-1:0]              dims_reg;
    logic [ilt_pkg::OP_W-1:0]   op_reg;
    logic [IW-1:0]              id_reg;
    logic                       lastp_reg;
    logic [ND-1:0]              valid_reg;
    logic [ND-1:0]              valid_next;
    logic [ND-1:0]              mark_reg;
    logic [ND-1:0]              mark_next;
    logic [DW-1:0]              scan_idx_reg;
    logic                       pend_valid_reg;
    logic [IW-1:0]              pend_id_reg;
    logic                       out_valid_reg;
    logic [IW-1:0]              out_id_reg;
    logic                       out_empty_reg;
    logic                       out_last_reg;

    logic [DW-1:0]  lim;
    logic [DW-1:0]  scan_idx_plus;
    logic [AW-1:0]  item_addr;
    logic [AW-1:0]  scan_addr;
    logic           in_range;
    logic [CW-1:0]  rd_data;
    logic [CW-1:0]  item_cnt;
    logic [CW-1:0]  scan_cnt;
    logic           qual;
    logic           out_free;
    logic           scan_stall;
    logic           scan_go;
    logic           finish_go;
    logic           item_write;
    logic           scan_write;
    logic           ram_rd_en;
    logic [AW-1:0]  ram_rd_addr;
    logic           ram_wr_en;
    logic [AW-1:0]  ram_wr_addr;
    logic [CW-1:0]  ram_wr_data;
    logic           load_out;
    logic [IW-1:0]  load_id;
    logic           load_empty;
    logic           load_last;

    // ids at or above the limit are ignored and never scanned
    assign lim = (dims_reg > DW'(ilt_pkg::LIM_CAP)) ? DW'(ilt_pkg::LIM_CAP) : dims_reg;

    assign item_addr     = AW'(id_reg);
    assign scan_addr     = AW'(scan_idx_reg);
    assign scan_idx_plus = scan_idx_reg + DW'(1);
    assign in_range      = ({1'b0, id_reg} < lim);

    // an entry without its valid bit reads as zero
    assign item_cnt = valid_reg[item_addr] ? rd_data : '0;
    assign scan_cnt = valid_reg[scan_addr] ? rd_data : '0;

    assign qual       = mark_reg[scan_addr] && (scan_cnt != '0);
    assign out_free   = !out_valid_reg || m_tready;
    assign scan_stall = qual && pend_valid_reg && !out_free;
    assign scan_go    = cmd.scan_chk && !scan_stall;
    assign finish_go  = cmd.finish && out_free;

    assign item_write = cmd.item_wr && in_range;
    assign scan_write = scan_go && qual;

    always_comb begin
        ram_rd_en   = cmd.item_rd || cmd.scan_rd;
        ram_rd_addr = cmd.scan_rd ? scan_addr : item_addr;
        ram_wr_en   = item_write || scan_write;
        ram_wr_addr = scan_write ? scan_addr : item_addr;
        if (scan_write) begin
            ram_wr_data = (scan_cnt == ilt_pkg::COUNT_MAX) ? scan_cnt : scan_cnt + CW'(1);
        end else if (op_reg == ilt_pkg::OP_COUNT) begin
            ram_wr_data = (item_cnt == ilt_pkg::COUNT_MAX) ? item_cnt : item_cnt + CW'(1);
        end else begin
            ram_wr_data = (item_cnt == '0) ? item_cnt : item_cnt - CW'(1);
        end
    end

    ilt_ram #(
        .WIDTH (CW),
        .DEPTH (ND)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        valid_next = valid_reg;
        if (cmd.item_rd && (op_reg == ilt_pkg::OP_CLEAR)) begin
            for (int i = 0; i < ND; i++) begin
                if (i < int'(lim)) begin
                    valid_next[i] = 1'b0;
                end
            end
        end
        if (ram_wr_en) begin
            valid_next[ram_wr_addr] = 1'b1;
        end
    end

    always_comb begin
        mark_next = mark_reg;
        if (item_write && (op_reg == ilt_pkg::OP_CONTRACT)) begin
            mark_next[item_addr] = 1'b1;
        end
        if (finish_go) begin
            mark_next = '0;
        end
    end

    // a found id goes to pending; the one it displaces goes out without last
    always_comb begin
        load_out   = 1'b0;
        load_id    = pend_id_reg;
        load_empty = 1'b0;
        load_last  = 1'b0;
        if (scan_write && pend_valid_reg) begin
            load_out = 1'b1;
        end else if (finish_go) begin
            load_out   = 1'b1;
            load_last  = 1'b1;
            load_empty = !pend_valid_reg;
            load_id    = pend_valid_reg ? pend_id_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg       <= ilt_pkg::DIMS_RESET;
            valid_reg      <= '0;
            mark_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                dims_reg <= cfg_wr_data;
            end
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
            if (cmd.scan_init || finish_go) begin
                pend_valid_reg <= 1'b0;
            end else if (scan_write) begin
                pend_valid_reg <= 1'b1;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg    <= s_tuser;
            id_reg    <= s_tdata[IW-1:0];
            lastp_reg <= s_tlast;
        end
        if (cmd.scan_init) begin
            scan_idx_reg <= '0;
        end else if (scan_go) begin
            scan_idx_reg <= scan_idx_plus;
        end
        if (scan_write) begin
            pend_id_reg <= IW'(scan_idx_reg);
        end
        if (load_out) begin
            out_id_reg    <= load_id;
            out_empty_reg <= load_empty;
            out_last_reg  <= load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ilt_pkg::TDATA_W'(out_id_reg);
    assign m_tuser  = out_empty_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        stat              = '0;
        stat.op_update    = (op_reg == ilt_pkg::OP_COUNT) || (op_reg == ilt_pkg::OP_CONTRACT);
        stat.op_contract  = (op_reg == ilt_pkg::OP_CONTRACT);
        stat.last_of_pair = lastp_reg;
        stat.lim_zero     = (lim == '0);
        stat.scan_stall   = scan_stall;
        stat.scan_at_end  = (scan_idx_plus == lim);
        stat.out_free     = out_free;
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> out_free)
        else $error("result register loaded while holding an untaken result");

    a_marks_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        finish_go |=> (mark_reg == '0))
        else $error("marks not cleared after emission");

    a_empty_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_empty_reg) |-> (out_last_reg && (out_id_reg == '0)))
        else $error("empty result without last or with nonzero id");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_chk |-> (scan_idx_reg < lim))
        else $error("scan index beyond ids in use");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench: self-checking bench for index_liveness_table, random and directed
// requests against a cycle-free predictor. Depends on ilt_pkg and the rtl.
`timescale 1ns / 1ps

module testbench;
    import ilt_pkg::*;

    // the one operation value the block must ignore
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
    // settle time for a contract with last set to sweep every id in use, plus slack
    localparam int SCAN_SETTLE = 2 * MAX_DIMS + 16;
    localparam int RANDOM_ITEMS = 100;

    typedef struct packed {
        logic [ID_W-1:0] dim;
        logic            empty;
        logic            last;
    } kept_dim_t;

    // predicts the kept ids of each contraction and checks them in order
    class liveness_scoreboard;
        logic [COUNT_BITS-1:0] occ[MAX_DIMS];
        bit                    marked[MAX_DIMS];
        logic [DIMS_W-1:0]     dims;
        kept_dim_t             pending[$];
        int errors, requests, results, empties, emissions, writes;

        function new();
            int i;
            for (i = 0; i < MAX_DIMS; i++) begin
                occ[i] = '0;
                marked[i] = 1'b0;
            end
            dims = DIMS_RESET;
            errors = 0;
            requests = 0;
            results = 0;
            empties = 0;
            emissions = 0;
            writes = 0;
        endfunction

        function int id_limit();
            int lim;
            lim = dims;
            if (lim > LIM_CAP) lim = LIM_CAP;
            return lim;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic lastp);
            int lim, i, n;
            kept_dim_t r;
            lim = id_limit();
            requests++;
            case (op)
                OP_CLEAR: begin
                    for (i = 0; i < lim; i++) occ[i] = '0;
                end
                OP_COUNT: begin
                    if (id < lim && occ[id] != COUNT_MAX) occ[id]++;
                end
                OP_CONTRACT: begin
                    if (id < lim) begin
                        if (occ[id] != '0) occ[id]--;
                        marked[id] = 1'b1;
                    end
                    if (lastp) begin
                        // ascending sweep: survivors go out and get their count back
                        n = 0;
                        for (i = 0; i < lim; i++) begin
                            if (marked[i] && occ[i] != '0) begin
                                r.dim = ID_W'(i);
                                r.empty = 1'b0;
                                r.last = 1'b0;
                                pending = {pending, r};
                                n++;
                                if (occ[i] != COUNT_MAX) occ[i]++;
                            end
                        end
                        for (i = 0; i < MAX_DIMS; i++) marked[i] = 1'b0;
                        if (n == 0) begin
                            r.dim = '0;
                            r.empty = 1'b1;
                            r.last = 1'b1;
                            pending = {pending, r};
                            empties++;
                        end else begin
                            pending[pending.size() - 1].last = 1'b1;
                        end
                        emissions++;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [ID_W-1:0] id, logic empty, logic last_flag);
            kept_dim_t want;
            results++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual dim %0d empty %b last %b",
                         $time, id, empty, last_flag);
                return;
            end
            want = pending.pop_front();
            if (id !== want.dim) begin
                errors++;
                $display("%0t: out_dim_id mismatch: expected %0d, actual %0d",
                         $time, want.dim, id);
            end
            if (empty !== want.empty) begin
                errors++;
                $display("%0t: is_empty mismatch: expected %b, actual %b",
                         $time, want.empty, empty);
            end
            if (last_flag !== want.last) begin
                errors++;
                $display("%0t: last mismatch: expected %b, actual %b",
                         $time, want.last, last_flag);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [DIMS_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    bit                   idle_en = 1'b1;
    liveness_scoreboard   sb;

    index_liveness_table uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!idle_en) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ids mostly inside the range in use, some anywhere
    function automatic logic [ID_W-1:0] pick_id(int lim);
        if (lim == 0 || $urandom_range(0, 9) == 0) return ID_W'($urandom_range(0, 63));
        return ID_W'($urandom_range(0, lim - 1));
    endfunction

    // called and returns at a falling edge
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                input logic lastp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {{(TDATA_W - ID_W){1'b0}}, id};
        s_tlast = lastp;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, id, lastp);
        @(negedge aclk);
    endtask

    // sender holds off until every kept id is back, then lets the block settle
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_dims(input logic [DIMS_W-1:0] value);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.dims = value;
        sb.writes++;
    endtask

    // result side back-pressure
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[ID_W-1:0], m_tuser, m_tlast);
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results still expected", sb.pending.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [ID_W-1:0]   live_ids[$];
        logic [ID_W-1:0]   id;
        logic [DIMS_W-1:0] next_dims;
        int random_items, n_count, n_contract, k, r, lim;

        sb = new();
        random_items = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: every operation, ignored flags, saturation at zero, empty runs
        write_dims(DIMS_W'(64));
        send_request(OP_CLEAR, 6'd17, 1'b1);
        send_request(OP_COUNT, 6'd0, 1'b0);
        send_request(OP_COUNT, 6'd63, 1'b0);
        send_request(OP_COUNT, 6'd63, 1'b0);
        send_request(OP_COUNT, 6'd5, 1'b1);
        send_request(OP_UNKNOWN, 6'd42, 1'b1);
        send_request(OP_CONTRACT, 6'd0, 1'b0);
        send_request(OP_CONTRACT, 6'd63, 1'b0);
        send_request(OP_CONTRACT, 6'd7, 1'b0);
        send_request(OP_CONTRACT, 6'd5, 1'b1);
        send_request(OP_CONTRACT, 6'd1, 1'b1);
        send_request(OP_COUNT, 6'd20, 1'b0);
        send_request(OP_COUNT, 6'd20, 1'b0);
        send_request(OP_CONTRACT, 6'd20, 1'b0);
        send_request(OP_CONTRACT, 6'd20, 1'b1);
        send_request(OP_CLEAR, 6'd0, 1'b1);
        send_request(OP_CONTRACT, 6'd63, 1'b1);
        send_request(OP_COUNT, 6'd10, 1'b0);
        send_request(OP_COUNT, 6'd10, 1'b0);
        send_request(OP_COUNT, 6'd30, 1'b0);
        send_request(OP_COUNT, 6'd30, 1'b0);
        send_request(OP_CONTRACT, 6'd10, 1'b0);
        send_request(OP_CONTRACT, 6'd30, 1'b1);

        // nothing in use: clear is a no-op, every emission is empty
        write_dims(DIMS_W'(0));
        send_request(OP_COUNT, 6'd3, 1'b0);
        send_request(OP_CONTRACT, 6'd3, 1'b1);
        send_request(OP_CLEAR, 6'd0, 1'b0);
        send_request(OP_CONTRACT, 6'd0, 1'b1);

        // register above the table size, count saturation, then a sweep over even ids
        write_dims(DIMS_W'(127));
        idle_en = 1'b0;
        repeat (257) send_request(OP_COUNT, 6'd50, 1'b0);
        send_request(OP_CONTRACT, 6'd50, 1'b1);
        send_request(OP_COUNT, 6'd50, 1'b0);
        send_request(OP_CONTRACT, 6'd50, 1'b1);
        idle_en = 1'b1;
        for (k = 0; k < MAX_DIMS; k += 4) begin
            send_request(OP_COUNT, ID_W'(k), 1'b0);
            send_request(OP_COUNT, ID_W'(k), 1'b0);
        end
        for (k = 0; k < MAX_DIMS; k += 2)
            send_request(OP_CONTRACT, ID_W'(k), k == MAX_DIMS - 2);

        // a single id in use: ids above it are dropped, clear touches only id 0
        write_dims(DIMS_W'(1));
        send_request(OP_COUNT, 6'd0, 1'b0);
        send_request(OP_COUNT, 6'd1, 1'b0);
        send_request(OP_CONTRACT, 6'd1, 1'b1);
        send_request(OP_CONTRACT, 6'd0, 1'b1);
        send_request(OP_CLEAR, 6'd0, 1'b0);
        send_request(OP_CONTRACT, 6'd0, 1'b1);
        write_dims(DIMS_W'(64));

        // random contraction pairs: occurrences, operand ids, last on the final one
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                r = $urandom_range(0, 19);
                if (r < 5)       next_dims = DIMS_W'(64);
                else if (r < 7)  next_dims = DIMS_W'(1);
                else if (r < 9)  next_dims = DIMS_W'($urandom_range(65, 127));
                else if (r == 9) next_dims = DIMS_W'(0);
                else             next_dims = DIMS_W'($urandom_range(2, 63));
                write_dims(next_dims);
            end
            idle_en = ($urandom_range(0, 3) != 0);
            lim = sb.id_limit();
            if ($urandom_range(0, 3) == 0)
                send_request(OP_CLEAR, ID_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            live_ids.delete();
            n_count = $urandom_range(1, 12);
            for (k = 0; k < n_count; k++) begin
                id = pick_id(lim);
                live_ids = {live_ids, id};
                send_request(OP_COUNT, id, $urandom_range(0, 7) == 0);
                random_items++;
            end
            n_contract = $urandom_range(1, 8);
            for (k = 0; k < n_contract; k++) begin
                if (k == n_contract - 1 && $urandom_range(0, 9) == 0)
                    wait_drained();
                if ($urandom_range(0, 3) != 0)
                    id = live_ids[$urandom_range(0, live_ids.size() - 1)];
                else
                    id = pick_id(lim);
                // now and then the pair is left open and marks carry over
                send_request(OP_CONTRACT, id,
                             k == n_contract - 1 && $urandom_range(0, 9) != 0);
                random_items++;
            end
            if ($urandom_range(0, 4) == 0) begin
                n_count = $urandom_range(1, 4);
                for (k = 0; k < n_count; k++)
                    send_request(OP_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, 63)),
                                 1'($urandom_range(0, 1)));
            end
        end

        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SCAN_SETTLE) @(posedge aclk);

        $display("run covered %0d requests and %0d register writes", sb.requests, sb.writes);
        $display("%0d contractions gave %0d results, %0d of them empty",
                 sb.emissions, sb.results, sb.empties);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ilt_pkg.sv
hw/rtl/ilt_ram.sv
hw/rtl/ilt_ctrl.sv
hw/rtl/ilt_dp.sv
hw/rtl/index_liveness_table.sv
tb/testbench.sv
